/* src/rhlc_pkg.sv */
// Package: shared types, codes and helpers of the radio handshake link controller.
`timescale 1ns / 1ps
`default_nettype none

package rhlc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_NODE_ADDR = 2'd0;
    localparam logic [1:0] CFG_MAX_PL    = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIM = 2'd2;

    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  NODE_ADDR_RST = 8'd0;
    localparam logic [7:0]  MAX_PL_RST    = 8'd51;
    localparam logic [15:0] RETRY_LIM_RST = 16'd3;

    // Reply format
    localparam logic [7:0] REPLY_LEN  = 8'd2;
    localparam logic [7:0] HS_COMMAND = 8'd0;

    typedef enum logic [2:0] {
        F_SEND      = 3'd0,
        F_TX_DONE   = 3'd1,
        F_RX_DONE   = 3'd2,
        F_HS_TO     = 3'd3,
        F_ACK_TO    = 3'd4,
        F_RETRY_TMR = 3'd5,
        F_WDOG      = 3'd6
    } func_t;

    typedef enum logic [9:0] {
        PH_IDLE       = 10'b00_0000_0001,
        PH_HS_TX      = 10'b00_0000_0010,
        PH_HS_RX      = 10'b00_0000_0100,
        PH_DATA_TX    = 10'b00_0000_1000,
        PH_DATA_RX    = 10'b00_0001_0000,
        PH_SENT       = 10'b00_0010_0000,
        PH_RETRY_CFG  = 10'b00_0100_0000,
        PH_RETRY      = 10'b00_1000_0000,
        PH_ERROR      = 10'b01_0000_0000,
        PH_WAIT_RETRY = 10'b10_0000_0000
    } phase_t;

    // Link state codes as seen on the result port
    localparam logic [3:0] LS_IDLE       = 4'd0;
    localparam logic [3:0] LS_HS_TX      = 4'd1;
    localparam logic [3:0] LS_HS_RX      = 4'd2;
    localparam logic [3:0] LS_DATA_TX    = 4'd3;
    localparam logic [3:0] LS_DATA_RX    = 4'd4;
    localparam logic [3:0] LS_SENT       = 4'd5;
    localparam logic [3:0] LS_RETRY_CFG  = 4'd6;
    localparam logic [3:0] LS_RETRY      = 4'd7;
    localparam logic [3:0] LS_ERROR      = 4'd8;
    localparam logic [3:0] LS_WAIT_RETRY = 4'd9;

    localparam logic [1:0] DS_FAILED       = 2'd0;
    localparam logic [1:0] DS_TRANSMITTING = 2'd1;
    localparam logic [1:0] DS_DELIVERED    = 2'd2;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG = 2'd1;
    localparam logic [1:0] ERR_REFUSED  = 2'd2;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_SEND_HDR = 3'd1;
    localparam logic [2:0] CMD_SEND_DAT = 3'd2;
    localparam logic [2:0] CMD_RX_START = 3'd3;
    localparam logic [2:0] CMD_STANDBY  = 3'd4;

    localparam logic [2:0] STOP_NONE  = 3'b000;
    localparam logic [2:0] STOP_ACK   = 3'b010;
    localparam logic [2:0] STOP_RX    = 3'b011;
    localparam logic [2:0] STOP_RETRY = 3'b100;
    localparam logic [2:0] STOP_ALL   = 3'b111;

    localparam logic [2:0] TS_NONE      = 3'd0;
    localparam logic [2:0] TS_HANDSHAKE = 3'd1;
    localparam logic [2:0] TS_ACK_ACK   = 3'd2;
    localparam logic [2:0] TS_ACK_TX    = 3'd3;
    localparam logic [2:0] TS_RETRY     = 3'd4;

    typedef struct packed {
        logic [7:0]  node_addr;
        logic [7:0]  max_pl;
        logic [15:0] retry_lim;
    } cfg_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] length;
        logic [7:0] channel;
        logic       rx_ok;
        logic [7:0] rx_first_byte;
        logic [7:0] rx_second_byte;
        logic       radio_ok;
    } item_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  dstat;
        logic [31:0] fcnt;
        logic [7:0]  exp_ch;
    } link_st_t;

    typedef struct packed {
        logic [3:0]  link_state;
        logic [1:0]  data_status;
        logic [1:0]  error_code;
        logic [2:0]  radio_cmd;
        logic [7:0]  header_channel;
        logic [2:0]  timer_stop_mask;
        logic [2:0]  timer_start;
        logic [31:0] frame_count;
    } result_t;

    function automatic logic [3:0] phase_code(input phase_t ph);
        logic [3:0] code;
        begin
            unique case (ph)
                PH_IDLE:       code = LS_IDLE;
                PH_HS_TX:      code = LS_HS_TX;
                PH_HS_RX:      code = LS_HS_RX;
                PH_DATA_TX:    code = LS_DATA_TX;
                PH_DATA_RX:    code = LS_DATA_RX;
                PH_SENT:       code = LS_SENT;
                PH_RETRY_CFG:  code = LS_RETRY_CFG;
                PH_RETRY:      code = LS_RETRY;
                PH_ERROR:      code = LS_ERROR;
                PH_WAIT_RETRY: code = LS_WAIT_RETRY;
                default:       code = LS_IDLE;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

/* src/rhlc_step.sv */
// Event decoder: next link state and result fields for one event.
`timescale 1ns / 1ps
`default_nettype none

module rhlc_step
    import rhlc_pkg::*;
(
    input  var cfg_t     cfg,
    input  var item_t    item,
    input  var link_st_t st,
    output link_st_t     st_next,
    output result_t      res
);

    logic [7:0] hdr_ch;
    logic       below_limit;
    logic       addr_match;
    logic       len_match;
    logic [2:0] err;
    logic [2:0] cmd;
    logic [7:0] hdr;
    logic [2:0] stop;
    logic [2:0] start;
    logic [1:0] err_code;

    assign hdr_ch      = (func_t'(item.func) == F_RETRY_TMR) ? st.exp_ch : item.channel;
    assign below_limit = st.fcnt < {16'd0, cfg.retry_lim};
    assign addr_match  = item.rx_first_byte == cfg.node_addr;
    assign len_match   = item.length == REPLY_LEN;
    assign err         = {1'b0, err_code};

    always_comb
    begin
        st_next  = st;
        err_code = ERR_OK;
        cmd      = CMD_NONE;
        hdr      = 8'd0;
        stop     = STOP_NONE;
        start    = TS_NONE;

        unique case (func_t'(item.func))
            F_SEND, F_RETRY_TMR:
            begin
                if (func_t'(item.func) == F_SEND)
                begin
                    st_next.dstat = DS_FAILED;
                end
                else
                begin
                    stop = STOP_RETRY;
                end
                if (func_t'(item.func) == F_SEND && item.length > cfg.max_pl)
                begin
                    err_code = ERR_TOO_LONG;
                end
                else
                begin
                    st_next.exp_ch = hdr_ch;
                    cmd            = CMD_SEND_HDR;
                    hdr            = hdr_ch;
                    if (item.radio_ok)
                    begin
                        st_next.dstat = DS_TRANSMITTING;
                        st_next.fcnt  = st.fcnt + 32'd1;
                        st_next.phase = PH_HS_TX;
                        start         = TS_HANDSHAKE;
                    end
                    else
                    begin
                        err_code = ERR_REFUSED;
                    end
                end
            end
            F_TX_DONE:
            begin
                if (st.phase == PH_HS_TX || st.phase == PH_DATA_TX)
                begin
                    cmd = CMD_RX_START;
                    if (!item.radio_ok)
                        st_next.phase = PH_RETRY;
                    else if (st.phase == PH_HS_TX)
                        st_next.phase = PH_HS_RX;
                    else
                        st_next.phase = PH_DATA_RX;
                end
                else
                begin
                    st_next.phase = PH_RETRY_CFG;
                end
            end
            F_RX_DONE:
            begin
                stop = STOP_RX;
                if (item.rx_ok)
                begin
                    if (st.phase == PH_HS_RX)
                    begin
                        if (len_match && addr_match && item.rx_second_byte == HS_COMMAND)
                        begin
                            cmd = CMD_SEND_DAT;
                            if (item.radio_ok)
                            begin
                                st_next.phase = PH_DATA_TX;
                                start         = TS_ACK_TX;
                            end
                            else
                            begin
                                st_next.phase = PH_RETRY_CFG;
                            end
                        end
                        else
                        begin
                            st_next.phase = PH_RETRY_CFG;
                        end
                    end
                    else if (st.phase == PH_DATA_RX)
                    begin
                        if (len_match && addr_match && item.rx_second_byte == st.exp_ch)
                        begin
                            st_next.phase = PH_SENT;
                            st_next.dstat = DS_DELIVERED;
                        end
                        else
                        begin
                            st_next.phase = PH_RETRY_CFG;
                        end
                    end
                    else
                    begin
                        st_next.phase = PH_RETRY;
                    end
                end
            end
            F_HS_TO, F_WDOG:
            begin
                if (func_t'(item.func) == F_HS_TO)
                begin
                    st_next.phase = PH_ERROR;
                    stop          = STOP_ALL;
                    cmd           = CMD_STANDBY;
                end
                // arm the retry only below the limit
                if (below_limit)
                begin
                    start         = TS_RETRY;
                    st_next.phase = PH_WAIT_RETRY;
                    st_next.dstat = DS_TRANSMITTING;
                end
                else
                begin
                    st_next.dstat = DS_FAILED;
                end
            end
            F_ACK_TO:
            begin
                st_next.phase = PH_ERROR;
                stop          = STOP_ACK;
                cmd           = CMD_STANDBY;
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

    always_comb
    begin
        res.link_state      = phase_code(st_next.phase);
        res.data_status     = st_next.dstat;
        res.error_code      = err[1:0];
        res.radio_cmd       = cmd;
        res.header_channel  = hdr;
        res.timer_stop_mask = stop;
        res.timer_start     = start;
        res.frame_count     = st_next.fcnt;
    end

endmodule

`default_nettype wire

/* src/radio_handshake_link_controller.sv */
// Top level: event input register, link state, result register and config port.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | sink      | in_valid / in_stall    | func, length, channel, rx_ok, rx bytes,
//          |           |                        | radio_ok
//  out     | source    | out_valid / out_stall  | link_state .. frame_count
//  cfg     | sink      | cfg_we                 | cfg_index, cfg_data
//
// One event per cycle sustained while the result side is not stalled; a beat taken into
// the event register has its result loaded into the result register once the result
// register is free, through the combinational decode in rhlc_step.
// Reset returns the link to idle with delivery failed, frame counter zero and registers
// at their defaults. A stalled result holds the result register; an empty event register
// still takes one more beat before in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module radio_handshake_link_controller
    import rhlc_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,

    input  wire                  cfg_we,
    input  wire [1:0]            cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,

    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire [2:0]            func,
    input  wire [7:0]            length,
    input  wire [7:0]            channel,
    input  wire                  rx_ok,
    input  wire [7:0]            rx_first_byte,
    input  wire [7:0]            rx_second_byte,
    input  wire                  radio_ok,

    output logic                 out_valid,
    input  wire                  out_stall,
    output logic [3:0]           link_state,
    output logic [1:0]           data_status,
    output logic [1:0]           error_code,
    output logic [2:0]           radio_cmd,
    output logic [7:0]           header_channel,
    output logic [2:0]           timer_stop_mask,
    output logic [2:0]           timer_start,
    output logic [31:0]          frame_count
);

    cfg_t     cfg_reg;
    link_st_t st_reg;
    link_st_t st_next;
    item_t    item_reg;
    logic     in_vld_reg;
    result_t  res_reg;
    result_t  res_next;
    logic     out_vld_reg;
    logic     out_free;

    assign out_free = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_addr <= NODE_ADDR_RST;
            cfg_reg.max_pl    <= MAX_PL_RST;
            cfg_reg.retry_lim <= RETRY_LIM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NODE_ADDR: cfg_reg.node_addr <= cfg_data[7:0];
                CFG_MAX_PL:    cfg_reg.max_pl    <= cfg_data[7:0];
                CFG_RETRY_LIM: cfg_reg.retry_lim <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Event register: take a beat whenever it is not held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.func           <= func;
            item_reg.length         <= length;
            item_reg.channel        <= channel;
            item_reg.rx_ok          <= rx_ok;
            item_reg.rx_first_byte  <= rx_first_byte;
            item_reg.rx_second_byte <= rx_second_byte;
            item_reg.radio_ok       <= radio_ok;
        end
    end

    rhlc_step u_step (
        .cfg     (cfg_reg),
        .item    (item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // Advance link state and result together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            st_reg.phase  <= PH_IDLE;
            st_reg.dstat  <= DS_FAILED;
            st_reg.fcnt   <= 32'd0;
            st_reg.exp_ch <= 8'd0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
            if (in_vld_reg)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_vld_reg;
    assign link_state      = res_reg.link_state;
    assign data_status     = res_reg.data_status;
    assign error_code      = res_reg.error_code;
    assign radio_cmd       = res_reg.radio_cmd;
    assign header_channel  = res_reg.header_channel;
    assign timer_stop_mask = res_reg.timer_stop_mask;
    assign timer_start     = res_reg.timer_start;
    assign frame_count     = res_reg.frame_count;

endmodule

`default_nettype wire

/* src/rhlc_checker.sv */
// Port-level checker for the radio handshake link controller, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module rhlc_checker
    import rhlc_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  cfg_we,
    input wire [1:0]            cfg_index,
    input wire [CFG_DATA_W-1:0] cfg_data,
    input wire                  in_valid,
    input wire                  in_stall,
    input wire [2:0]            func,
    input wire [7:0]            length,
    input wire [7:0]            channel,
    input wire                  rx_ok,
    input wire [7:0]            rx_first_byte,
    input wire [7:0]            rx_second_byte,
    input wire                  radio_ok,
    input wire                  out_valid,
    input wire                  out_stall,
    input wire [3:0]            link_state,
    input wire [1:0]            data_status,
    input wire [1:0]            error_code,
    input wire [2:0]            radio_cmd,
    input wire [7:0]            header_channel,
    input wire [2:0]            timer_stop_mask,
    input wire [2:0]            timer_start,
    input wire [31:0]           frame_count
);

    // A held result beat keeps its link state and frame count
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(link_state) && $stable(frame_count))
        else $error("result beat changed while stalled");

    a_hdr_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && radio_cmd != CMD_SEND_HDR |-> header_channel == 8'd0)
        else $error("header channel set without a header send");

    a_too_long_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_TOO_LONG |->
            radio_cmd == CMD_NONE && timer_start == TS_NONE && data_status == DS_FAILED)
        else $error("oversized payload issued an action");

    a_hs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timer_start == TS_HANDSHAKE |->
            link_state == LS_HS_TX && data_status == DS_TRANSMITTING
            && radio_cmd == CMD_SEND_HDR && error_code == ERR_OK)
        else $error("handshake timer armed outside a good header send");

endmodule

bind radio_handshake_link_controller rhlc_checker u_rhlc_checker (.*);

`default_nettype wire

/* tb/rhlc_link_checker.sv */
// Checker: watches the event and result channels, predicts each result and compares.
`timescale 1ns / 1ps

module rhlc_link_checker
    import rhlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [2:0]            func,
    input  logic [7:0]            length,
    input  logic [7:0]            channel,
    input  logic                  rx_ok,
    input  logic [7:0]            rx_first_byte,
    input  logic [7:0]            rx_second_byte,
    input  logic                  radio_ok,

    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [3:0]            link_state,
    input  logic [1:0]            data_status,
    input  logic [1:0]            error_code,
    input  logic [2:0]            radio_cmd,
    input  logic [7:0]            header_channel,
    input  logic [2:0]            timer_stop_mask,
    input  logic [2:0]            timer_start,
    input  logic [31:0]           frame_count,

    output int                    fail_count,
    output int                    pending
);

    cfg_t        regs;
    logic [3:0]  ls;
    logic [1:0]  dstat;
    logic [31:0] fcnt;
    logic [7:0]  exp_ch;

    result_t     link_results_q[$];

    initial fail_count = 0;

    function automatic void issue_header(inout result_t r, input logic [7:0] ch,
                                         input logic ok);
        r.radio_cmd      = CMD_SEND_HDR;
        r.header_channel = ch;
        if (ok)
        begin
            dstat         = DS_TRANSMITTING;
            fcnt          = fcnt + 32'd1;
            ls            = LS_HS_TX;
            r.timer_start = TS_HANDSHAKE;
        end
        else
        begin
            r.error_code = ERR_REFUSED;
        end
    endfunction

    function automatic void arm_retry(inout result_t r);
        if (fcnt < {16'd0, regs.retry_lim})
        begin
            r.timer_start = TS_RETRY;
            ls            = LS_WAIT_RETRY;
            dstat         = DS_TRANSMITTING;
        end
        else
        begin
            dstat = DS_FAILED;
        end
    endfunction

    function automatic result_t step_link(input item_t ev);
        result_t r;
        r = '0;
        case (func_t'(ev.func))
            F_SEND:
            begin
                dstat = DS_FAILED;
                if (ev.length > regs.max_pl)
                    r.error_code = ERR_TOO_LONG;
                else
                begin
                    exp_ch = ev.channel;
                    issue_header(r, ev.channel, ev.radio_ok);
                end
            end
            F_TX_DONE:
            begin
                if (ls == LS_HS_TX || ls == LS_DATA_TX)
                begin
                    ls          = (ls == LS_HS_TX) ? LS_HS_RX : LS_DATA_RX;
                    r.radio_cmd = CMD_RX_START;
                    if (!ev.radio_ok)
                        ls = LS_RETRY;
                end
                else
                    ls = LS_RETRY_CFG;
            end
            F_RX_DONE:
            begin
                r.timer_stop_mask = STOP_RX;
                // a failed reception only stops the receive timers
                if (ev.rx_ok)
                begin
                    if (ls == LS_HS_RX)
                    begin
                        if (ev.length == REPLY_LEN && ev.rx_first_byte == regs.node_addr
                            && ev.rx_second_byte == HS_COMMAND)
                        begin
                            r.radio_cmd = CMD_SEND_DAT;
                            if (ev.radio_ok)
                            begin
                                ls            = LS_DATA_TX;
                                r.timer_start = TS_ACK_TX;
                            end
                            else
                                ls = LS_RETRY_CFG;
                        end
                        else
                            ls = LS_RETRY_CFG;
                    end
                    else if (ls == LS_DATA_RX)
                    begin
                        if (ev.length == REPLY_LEN && ev.rx_first_byte == regs.node_addr
                            && ev.rx_second_byte == exp_ch)
                        begin
                            ls    = LS_SENT;
                            dstat = DS_DELIVERED;
                        end
                        else
                            ls = LS_RETRY_CFG;
                    end
                    else
                        ls = LS_RETRY;
                end
            end
            F_HS_TO:
            begin
                ls                = LS_ERROR;
                r.timer_stop_mask = STOP_ALL;
                r.radio_cmd       = CMD_STANDBY;
                arm_retry(r);
            end
            F_ACK_TO:
            begin
                ls                = LS_ERROR;
                r.timer_stop_mask = STOP_ACK;
                r.radio_cmd       = CMD_STANDBY;
            end
            F_RETRY_TMR:
            begin
                r.timer_stop_mask = STOP_RETRY;
                issue_header(r, exp_ch, ev.radio_ok);
            end
            F_WDOG:
                arm_retry(r);
            default:
            begin
            end
        endcase
        r.link_state  = ls;
        r.data_status = dstat;
        r.frame_count = fcnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t seen;
        if (!rst_n)
        begin
            regs.node_addr = NODE_ADDR_RST;
            regs.max_pl    = MAX_PL_RST;
            regs.retry_lim = RETRY_LIM_RST;
            ls             = LS_IDLE;
            dstat          = DS_FAILED;
            fcnt           = '0;
            exp_ch         = '0;
            link_results_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NODE_ADDR: regs.node_addr = cfg_data[7:0];
                    CFG_MAX_PL:    regs.max_pl    = cfg_data[7:0];
                    CFG_RETRY_LIM: regs.retry_lim = cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen = {link_state, data_status, error_code, radio_cmd, header_channel,
                        timer_stop_mask, timer_start, frame_count};
                if (link_results_q.size() == 0)
                begin
                    $error("result beat with no event waiting for it");
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = link_results_q.pop_front();
                    check_field("link_state", 32'(want.link_state),
                                32'(seen.link_state));
                    check_field("data_status", 32'(want.data_status),
                                32'(seen.data_status));
                    check_field("error_code", 32'(want.error_code),
                                32'(seen.error_code));
                    check_field("radio_cmd", 32'(want.radio_cmd),
                                32'(seen.radio_cmd));
                    check_field("header_channel", 32'(want.header_channel),
                                32'(seen.header_channel));
                    check_field("timer_stop_mask", 32'(want.timer_stop_mask),
                                32'(seen.timer_stop_mask));
                    check_field("timer_start", 32'(want.timer_start),
                                32'(seen.timer_start));
                    check_field("frame_count", want.frame_count, seen.frame_count);
                end
            end
            if (in_valid && !in_stall)
                link_results_q.push_back(step_link({func, length, channel, rx_ok,
                                                    rx_first_byte, rx_second_byte,
                                                    radio_ok}));
            pending <= link_results_q.size();
        end
    end

endmodule

/* tb/radio_handshake_link_controller_tb.sv */
// Testbench top: clock, reset, event and config stimulus, stall generation and verdict.
`timescale 1ns / 1ps

module radio_handshake_link_controller_tb;
    import rhlc_pkg::*;

    localparam int DEAD_LIMIT = 2000;

    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [1:0]            cfg_index      = CFG_NODE_ADDR;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [2:0]            func           = F_SEND;
    logic [7:0]            length         = '0;
    logic [7:0]            channel        = 8'd1;
    logic                  rx_ok          = 1'b0;
    logic [7:0]            rx_first_byte  = '0;
    logic [7:0]            rx_second_byte = '0;
    logic                  radio_ok       = 1'b0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [3:0]            link_state;
    logic [1:0]            data_status;
    logic [1:0]            error_code;
    logic [2:0]            radio_cmd;
    logic [7:0]            header_channel;
    logic [2:0]            timer_stop_mask;
    logic [2:0]            timer_start;
    logic [31:0]           frame_count;

    int                    fail_count;
    int                    pending;

    // link settings as last programmed, used to build well-formed replies
    logic [7:0]            cur_addr  = NODE_ADDR_RST;
    logic [7:0]            cur_max   = MAX_PL_RST;
    logic [7:0]            cur_ch    = '0;
    logic                  no_idle   = 1'b0;
    int                    events_sent = 0;
    int                    stall_left  = 0;
    int                    dead_cycles = 0;

    radio_handshake_link_controller uut (.*);

    rhlc_link_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit one_in(input int n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    function automatic item_t noise_event();
        item_t ev;
        ev.func           = 3'($urandom_range(0, 6));
        ev.length         = 8'($urandom_range(0, 255));
        ev.channel        = 8'($urandom_range(1, 255));
        ev.rx_ok          = 1'($urandom_range(0, 1));
        ev.rx_first_byte  = 8'($urandom_range(0, 255));
        ev.rx_second_byte = 8'($urandom_range(0, 255));
        ev.radio_ok       = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    task automatic push_event(input item_t ev);
        if (!no_idle && one_in(6))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= ev.func;
        length         <= ev.length;
        channel        <= ev.channel;
        rx_ok          <= ev.rx_ok;
        rx_first_byte  <= ev.rx_first_byte;
        rx_second_byte <= ev.rx_second_byte;
        radio_ok       <= ev.radio_ok;
        if (ev.func == F_SEND && ev.length <= cur_max)
            cur_ch = ev.channel;
        events_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic tx_done_event();
        item_t ev;
        ev          = noise_event();
        ev.func     = F_TX_DONE;
        ev.radio_ok = !one_in(12);
        push_event(ev);
    endtask

    task automatic reply_event(input logic [7:0] second);
        item_t ev;
        ev                = noise_event();
        ev.func           = F_RX_DONE;
        ev.rx_ok          = !one_in(16);
        ev.radio_ok       = !one_in(12);
        ev.length         = one_in(16) ? ev.length : REPLY_LEN;
        ev.rx_first_byte  = one_in(16) ? ev.rx_first_byte : cur_addr;
        ev.rx_second_byte = one_in(16) ? ev.rx_second_byte : second;
        push_event(ev);
    endtask

    // now and then break the exchange with a timer or watchdog event
    task automatic side_event();
        item_t ev;
        if (one_in(10))
        begin
            ev      = noise_event();
            ev.func = 3'(F_HS_TO) + 3'($urandom_range(0, 3));
            push_event(ev);
        end
    endtask

    task automatic run_exchange();
        item_t ev;
        ev          = noise_event();
        ev.func     = F_SEND;
        ev.length   = (one_in(10) && cur_max != 8'hFF) ?
                      8'($urandom_range(cur_max + 1, 255)) : 8'($urandom_range(0, cur_max));
        ev.radio_ok = !one_in(12);
        push_event(ev);
        side_event();
        tx_done_event();
        side_event();
        reply_event(HS_COMMAND);
        side_event();
        tx_done_event();
        side_event();
        reply_event(cur_ch);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_link(input logic [7:0] addr, input logic [7:0] maxpl,
                                input logic [15:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NODE_ADDR;
        cfg_data  <= {8'h00, addr};
        @(posedge clk);
        cfg_index <= CFG_MAX_PL;
        cfg_data  <= {8'h00, maxpl};
        @(posedge clk);
        cfg_index <= CFG_RETRY_LIM;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_addr  = addr;
        cur_max   = maxpl;
    endtask

    task automatic run_phase(input logic [7:0] addr, input logic [7:0] maxpl,
                             input logic [15:0] lim, input int n);
        int target;
        drain();
        program_link(addr, maxpl, lim);
        target = events_sent + n;
        while (events_sent < target)
        begin
            if (one_in(4))
                push_event(noise_event());
            else
                run_exchange();
        end
    endtask

    // random stall bursts on the result side
    always @(posedge clk)
    begin
        if (!rst_n || no_idle)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (one_in(6))
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            dead_cycles <= 0;
        else if (dead_cycles == DEAD_LIMIT)
        begin
            $display("radio_handshake_link_controller test failed");
            $finish;
        end
        else
            dead_cycles <= dead_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats under reset defaults: address 0, payload 51, retry limit 3
        push_event({F_SEND,      8'd52,  8'd1,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_SEND,      8'd255, 8'd1,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_SEND,      8'd51,  8'd255, 1'b1, 8'h00, 8'h00, 1'b0});
        push_event({F_TX_DONE,   8'd0,   8'd1,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_RX_DONE,   8'd2,   8'd1,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_RX_DONE,   8'd2,   8'd1,   1'b0, 8'h00, 8'h00, 1'b1});
        push_event({F_SEND,      8'd0,   8'd7,   1'b0, 8'hFF, 8'hFF, 1'b1});
        push_event({F_TX_DONE,   8'd0,   8'd7,   1'b1, 8'h00, 8'h00, 1'b0});
        push_event({F_SEND,      8'd2,   8'd9,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_TX_DONE,   8'd0,   8'd9,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_RX_DONE,   8'd2,   8'd9,   1'b1, 8'h00, 8'h00, 1'b0});
        push_event({F_RETRY_TMR, 8'd0,   8'd1,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_TX_DONE,   8'd0,   8'd9,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_RX_DONE,   8'd2,   8'd9,   1'b1, 8'hFF, 8'h00, 1'b1});
        push_event({F_RETRY_TMR, 8'd0,   8'd1,   1'b1, 8'h00, 8'h00, 1'b0});
        push_event({F_HS_TO,     8'd0,   8'd1,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_WDOG,      8'd0,   8'd1,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_ACK_TO,    8'd0,   8'd1,   1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_SEND,      8'd51,  8'd128, 1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_TX_DONE,   8'd0,   8'd128, 1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_RX_DONE,   8'd2,   8'd128, 1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_TX_DONE,   8'd0,   8'd128, 1'b1, 8'h00, 8'h00, 1'b1});
        push_event({F_RX_DONE,   8'd2,   8'd128, 1'b1, 8'h00, 8'h80, 1'b1});
        push_event({F_RX_DONE,   8'd2,   8'd128, 1'b1, 8'h00, 8'h80, 1'b1});

        run_phase(8'h00, 8'd0,   16'd0,     300);
        run_phase(8'hFF, 8'd255, 16'hFFFF,  300);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd3, 300);
        run_phase(8'h5A, 8'd51, 16'($urandom_range(0, 2000)), 300);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), 300);
        // last stretch runs back to back with no stalls
        no_idle = 1'b1;
        run_phase(8'($urandom_range(0, 255)), 8'd255, 16'hFFFF, 300);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("radio_handshake_link_controller test passed");
        else
            $display("radio_handshake_link_controller test failed");
        $finish;
    end

endmodule
